FILE: sv/ptc_pkg.sv
// Package: shared types, codes and constants of the pointer tracker with click queue.
package ptc_pkg;

  // Default click queue depth
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  // Configuration port geometry and register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

  // Request operation codes
  localparam logic OP_REPORT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Request transaction payload
  typedef struct packed {
    logic               op;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]         buttons;
    logic               is_delta;
    logic [31:0]        time_ms;
  } req_t;

  // Event transaction payload
  typedef struct packed {
    logic signed [15:0] event_x;
    logic signed [15:0] event_y;
    logic [7:0]         event_buttons;
    logic [31:0]        event_time_ms;
    logic               was_pending;
    logic               from_queue;
  } evt_t;

  // One click queue entry
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         b;
    logic [31:0]        t;
  } click_t;

  // Control sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

endpackage

FILE: sv/ptc_stream_if.sv
// Interface: valid/ready channel carrying one payload per transaction.
interface ptc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/pointer_tracker_click_queue.sv
// Top level: pointer tracker with a click queue held in a synchronous memory.
//
// Channels: req_i carries pointer reports (op = report) and event reads
// (op = read); evt_o carries one event per read. Reports give no event.
// Configuration: cfg_we_i/cfg_idx_i/cfg_wdata_i write the screen width and
// height clamp bounds; the user must write them only while the block is idle (the block does not enforce it).
//
// Timing: a report is handled as it is taken: add, saturate, clamp and compare
// are combinational, with at most one queue write. A read with an empty queue
// loads the event register in the cycle it is taken; a read that pops a click
// first fills the registered read port of the click memory (ST_READ), then
// the event register. One request is in flight at a time; the next is taken in ST_IDLE
// once the event register is free or draining: reports then sustain one per cycle.
//
// Reset clears the position, buttons, time, queue pointers and flags, and
// empties the event register; the click memory is not cleared.
// When the receiver stalls, the event is held in the output register and
// req_i.ready stays low until it is taken.
module pointer_tracker_click_queue #(
  parameter int unsigned QueueDepth = ptc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ptc_stream_if.sink                      req_i,
  ptc_stream_if.source                    evt_o,
  input  logic                            cfg_we_i,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ptc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import ptc_pkg::*;

  localparam int unsigned IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(QueueDepth - 1);

  // Registers
  logic [CFG_DATA_W-1:0] scr_w_q, scr_h_q;
  logic signed [15:0]    cur_x_q, cur_y_q;
  logic [7:0]            cur_b_q;
  logic [31:0]           cur_t_q;
  logic [IdxW-1:0]       rd_idx_q, wr_idx_q;
  logic                  full_q, pend_q;
  state_e                state_q, state_d;
  logic                  evt_valid_q;
  evt_t                  evt_q;
  click_t                click_mem [QueueDepth];
  click_t                mem_rd_q;

  // Sequencer outputs
  logic req_ready;
  logic load_mem;

  req_t req;
  logic acc, acc_report, acc_read;
  logic out_free;

  assign req        = req_i.data;
  assign out_free   = !evt_valid_q || evt_o.ready;
  assign acc        = req_i.valid && req_ready;
  assign acc_report = acc && (req.op == OP_REPORT);
  assign acc_read   = acc && (req.op == OP_READ);

  // Work out the reported position: delta add, saturation, and clamping when the screen width is nonzero
  logic signed [16:0] sum_x, sum_y;
  logic signed [15:0] sat_x, sat_y, pos_x, pos_y, lo_x, lo_y;
  logic signed [15:0] w_m1, h_m1;
  logic signed [16:0] lim_w, lim_h;

  always_comb begin
    sum_x = {req.pos_x[15], req.pos_x};
    sum_y = {req.pos_y[15], req.pos_y};
    if (req.is_delta) begin
      sum_x = sum_x + {cur_x_q[15], cur_x_q};
      sum_y = sum_y + {cur_y_q[15], cur_y_q};
    end
    if (sum_x > 17'sd32767) sat_x = 16'sh7fff;
    else if (sum_x < -17'sd32768) sat_x = -16'sh8000;
    else sat_x = sum_x[15:0];
    if (sum_y > 17'sd32767) sat_y = 16'sh7fff;
    else if (sum_y < -17'sd32768) sat_y = -16'sh8000;
    else sat_y = sum_y[15:0];

    lim_w = signed'({2'b00, scr_w_q});
    lim_h = signed'({2'b00, scr_h_q});
    w_m1  = signed'({1'b0, scr_w_q}) - 16'sd1;
    h_m1  = signed'({1'b0, scr_h_q}) - 16'sd1;
    lo_x  = (sat_x < 16'sd0) ? 16'sd0 : sat_x;
    lo_y  = (sat_y < 16'sd0) ? 16'sd0 : sat_y;
    pos_x = sat_x;
    pos_y = sat_y;
    if (scr_w_q != '0) begin
      pos_x = ({lo_x[15], lo_x} >= lim_w) ? w_m1 : lo_x;
      pos_y = ({lo_y[15], lo_y} >= lim_h) ? h_m1 : lo_y;
    end
  end

  logic            changed, push, nonempty;
  logic [IdxW-1:0] wr_idx_nx, rd_idx_nx;

  assign changed   = (pos_x != cur_x_q) || (pos_y != cur_y_q) || (req.buttons != cur_b_q);
  assign push      = acc_report && changed && !full_q && (req.buttons != cur_b_q);
  assign nonempty  = full_q || (wr_idx_q != rd_idx_q);
  assign wr_idx_nx = (wr_idx_q == LastIdx) ? '0 : wr_idx_q + 1'b1;
  assign rd_idx_nx = (rd_idx_q == LastIdx) ? '0 : rd_idx_q + 1'b1;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc_read && nonempty) state_d = ST_READ;
      end
      ST_READ: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    req_ready = 1'b0;
    load_mem  = 1'b0;
    case (state_q)
      ST_IDLE: req_ready = out_free;
      ST_READ: load_mem  = 1'b1;
      default: begin
        req_ready = 1'b0;
        load_mem  = 1'b0;
      end
    endcase
  end

  assign req_i.ready = req_ready;
  assign evt_o.valid = evt_valid_q;
  assign evt_o.data  = evt_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= '0;
      scr_h_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_SCREEN_WIDTH)  scr_w_q <= cfg_wdata_i;
      if (cfg_idx_i == CFG_SCREEN_HEIGHT) scr_h_q <= cfg_wdata_i;
    end
  end

  // Pointer state, queue pointers and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      cur_b_q  <= '0;
      cur_t_q  <= '0;
      rd_idx_q <= '0;
      wr_idx_q <= '0;
      full_q   <= 1'b0;
      pend_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (acc_report && changed) begin
        cur_x_q <= pos_x;
        cur_y_q <= pos_y;
        cur_b_q <= req.buttons;
        cur_t_q <= req.time_ms;
        pend_q  <= 1'b1;
        if (push) begin
          wr_idx_q <= wr_idx_nx;
          if (wr_idx_nx == rd_idx_q) full_q <= 1'b1;
        end
      end
      if (acc_read) begin
        full_q <= 1'b0;
        pend_q <= 1'b0;
        if (nonempty) rd_idx_q <= rd_idx_nx;
      end
    end
  end

  // Click memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (push) begin
      click_mem[wr_idx_q] <= '{x: pos_x, y: pos_y, b: req.buttons, t: req.time_ms};
    end
    if (acc_read) mem_rd_q <= click_mem[rd_idx_q];
  end

  // Event output register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_valid_q <= 1'b0;
    end else if (load_mem || (acc_read && !nonempty)) begin
      evt_valid_q <= 1'b1;
    end else if (evt_o.ready) begin
      evt_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_mem) begin
      evt_q <= '{event_x: mem_rd_q.x, event_y: mem_rd_q.y, event_buttons: mem_rd_q.b,
                 event_time_ms: mem_rd_q.t, was_pending: 1'b1, from_queue: 1'b1};
    end else if (acc_read && !nonempty) begin
      evt_q <= '{event_x: cur_x_q, event_y: cur_y_q, event_buttons: cur_b_q,
                 event_time_ms: cur_t_q, was_pending: pend_q, from_queue: 1'b0};
    end
  end

endmodule

FILE: sv/ptc_checker.sv
// Checker: port-level assertions on the pointer tracker, bound to the top level.
module ptc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid,
  input logic req_ready,
  input logic req_op,
  input logic evt_valid,
  input logic evt_ready,
  input logic evt_was_pending,
  input logic evt_from_queue
);
  import ptc_pkg::*;

  // Hold a stalled event
  a_evt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid && !evt_ready |=> evt_valid)
    else $error("event dropped while stalled");

  // A popped click always counts as pending
  a_queue_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid && evt_from_queue |-> evt_was_pending)
    else $error("queued event without pending flag");

  // Take no request while an event is stalled
  a_no_accept_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid && !evt_ready |-> !(req_valid && req_ready))
    else $error("request taken while event stalled");

  // A report never produces an event
  a_report_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready && (req_op == OP_REPORT) && !evt_valid |=> !evt_valid)
    else $error("report produced an event");

endmodule

bind pointer_tracker_click_queue ptc_checker u_ptc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid       (req_i.valid),
  .req_ready       (req_i.ready),
  .req_op          (req_i.data.op),
  .evt_valid       (evt_o.valid),
  .evt_ready       (evt_o.ready),
  .evt_was_pending (evt_o.data.was_pending),
  .evt_from_queue  (evt_o.data.from_queue)
);
